/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside of reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside of reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/pwd_pkg.sv */
`timescale 1ns / 1ps

package pwd_pkg;

	// Parser phase of the front end.
	typedef enum logic [2:0] {
		PH_TAG,
		PH_VARINT,
		PH_FIXED,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_STOP
	} pwd_phase_t;

	// Result kinds.
	localparam logic [1:0] KIND_SCALAR  = 2'd0;
	localparam logic [1:0] KIND_HEADER  = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;
	localparam logic [1:0] KIND_END     = 2'd3;

	// End status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BUDGET    = 3'd1;
	localparam logic [2:0] ST_BAD_TAG   = 3'd2;
	localparam logic [2:0] ST_BAD_WIRE  = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;

	// Wire types.
	localparam logic [2:0] WIRE_VARINT  = 3'd0;
	localparam logic [2:0] WIRE_FIXED64 = 3'd1;
	localparam logic [2:0] WIRE_LEN     = 3'd2;
	localparam logic [2:0] WIRE_FIXED32 = 3'd5;

	// Master-side tdata layout, lowest bit first.
	localparam int OFS_FNUM   = 0;
	localparam int OFS_WIRE   = 31;
	localparam int OFS_VALUE  = 34;
	localparam int OFS_STATUS = 98;
	localparam int OFS_COUNT  = 101;
	localparam int TDATA_W    = 120;

	// One queue entry: an optional field result followed by an optional end result.
	typedef struct packed {
		logic        has_main;
		logic [1:0]  kind;
		logic [30:0] fnum;
		logic [2:0]  wtype;
		logic [63:0] value;
		logic        has_end;
		logic [2:0]  status;
		logic [15:0] count;
	} pwd_entry_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic full;
		logic empty;
	} pwd_qstat_t;

endpackage

/* sv/protobuf_wire_field_decoder_top.sv */
// Protocol Buffers wire field decoder.
// The slave stream carries one message byte per item: tdata is the byte and
// tlast marks the final byte of a message. The master stream carries results:
// tuser is the kind (scalar, length header, payload byte, end status), tlast
// is set on the last result that one input byte causes. The cfg_we/cfg_wdata
// port writes the per-message field budget; write it only while idle.
// The slave side takes one item per cycle while the result queue has room.
// The back end sends one result per cycle through its output register while
// the receiver takes them; a byte that both finishes a field and ends the
// message yields two results. A byte is decoded as it is accepted, and any
// entry it causes is written into the queue; the back end then loads that
// entry into its output register, which shows its first result on the master
// side. When the receiver stalls the queue fills and tready falls, and no
// result is lost or reordered. Reset empties the queue and the output
// register, returns the parser to the start of a message and sets the field
// budget to its maximum.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module protobuf_wire_field_decoder_top import pwd_pkg::*; #(
	parameter int FIELD_COUNT_BITS = 16,
	parameter int QUEUE_DEPTH      = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // data_byte
	input  logic               s_tlast,   // end_of_message
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata, // max_fields
	output logic               m_tvalid,
	input  logic               m_tready,
	// field_number[30:0], wire_type[33:31], value[97:34], status[100:98],
	// field_count[116:101], zero fill[119:117]
	output logic [TDATA_W-1:0] m_tdata,
	output logic [1:0]         m_tuser,   // kind
	output logic               m_tlast    // run_end
);

	pwd_entry_t push_entry;
	pwd_entry_t head;
	pwd_qstat_t qstat;
	logic       push;
	logic       pop;

	// Front end: decodes each accepted byte and pushes the results it causes.
	pwd_front #(
		.FIELD_COUNT_BITS(FIELD_COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.qstat     (qstat),
		.push      (push),
		.push_entry(push_entry)
	);

	// Short queue that lets the decoder run ahead of a stalled receiver.
	pwd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// Back end: splits each entry into one or two results on the master side.
	pwd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// An end result always closes the results of its byte.
	`ASSERT_IMP(a_end_is_last, clk, arst_n, m_tvalid && m_tuser == KIND_END, m_tlast, "end result without tlast")

	// Only end results carry a nonzero status.
	`ASSERT_IMP(a_field_status_ok, clk, arst_n, m_tvalid && m_tuser != KIND_END, m_tdata[OFS_STATUS +: 3] == ST_OK, "field result with nonzero status")

	// The last byte of a message always leaves an entry in the queue.
	`ASSERT_NXT(a_eom_queued, clk, arst_n, s_tvalid && s_tready && s_tlast, !qstat.empty, "end of message not queued")

endmodule

/* sv/pwd_front.sv */
`timescale 1ns / 1ps

module pwd_front import pwd_pkg::*; #(
	parameter int FIELD_COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  pwd_qstat_t  qstat,
	output logic        push,
	output pwd_entry_t  push_entry
);

	localparam int CW = (FIELD_COUNT_BITS > 16) ? FIELD_COUNT_BITS : 16;

	pwd_phase_t                  phase_q, phase_n;
	logic [63:0]                 acc_q, acc_n;
	logic [3:0]                  idx_q, idx_n;
	logic [30:0]                 field_q, field_n;
	logic [2:0]                  wire_q, wire_n;
	logic [31:0]                 rem_q, rem_n;
	logic [FIELD_COUNT_BITS-1:0] seen_q, seen_n;
	logic [2:0]                  stop_q, stop_n;
	logic [15:0]                 max_fields_q;

	logic        accept;
	logic [63:0] acc_v, acc_f;
	logic [6:0]  shamt;
	logic        vdone, vover;
	logic [3:0]  idx_inc;
	logic [31:0] rem_dec;
	logic        do_count, do_fail;
	logic [2:0]  fail_code;
	logic [CW-1:0] seen_ext, max_ext, seen_out;
	pwd_entry_t  e;

	assign s_tready = !qstat.full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		shamt    = 7'(idx_q) * 7'd7;
		acc_v    = acc_q | (64'(s_tdata[6:0]) << shamt);
		acc_f    = acc_q | (64'(s_tdata) << {idx_q[2:0], 3'b000});
		vdone    = !s_tdata[7];
		vover    = s_tdata[7] && (idx_q >= 4'd9);
		idx_inc  = idx_q + 4'd1;
		rem_dec  = (rem_q != 32'd0) ? rem_q - 32'd1 : rem_q;
		seen_ext = CW'(seen_q);
		max_ext  = CW'(max_fields_q);

		phase_n   = phase_q;
		acc_n     = acc_q;
		idx_n     = idx_q;
		field_n   = field_q;
		wire_n    = wire_q;
		rem_n     = rem_q;
		stop_n    = stop_q;
		do_count  = 1'b0;
		do_fail   = 1'b0;
		fail_code = ST_OK;

		e          = '0;
		e.kind     = KIND_SCALAR;
		e.fnum     = field_q;
		e.wtype    = wire_q;
		e.value    = acc_v;
		e.status   = ST_OK;

		unique case (phase_q)
			PH_TAG: begin
				if (idx_q == 4'd0 && seen_ext >= max_ext) begin
					do_fail   = 1'b1;
					fail_code = ST_BUDGET;
				end else if (vover) begin
					do_fail   = 1'b1;
					fail_code = ST_BAD_TAG;
				end else if (vdone) begin
					acc_n = '0;
					idx_n = '0;
					if (acc_v[63:3] == '0 || acc_v[63:34] != '0) begin
						do_fail   = 1'b1;
						fail_code = ST_BAD_TAG;
					end else begin
						field_n = acc_v[33:3];
						wire_n  = acc_v[2:0];
						unique case (acc_v[2:0])
							WIRE_VARINT:  phase_n = PH_VARINT;
							WIRE_FIXED64: begin
								phase_n = PH_FIXED;
								rem_n   = 32'd8;
							end
							WIRE_FIXED32: begin
								phase_n = PH_FIXED;
								rem_n   = 32'd4;
							end
							WIRE_LEN:     phase_n = PH_LENGTH;
							default: begin
								do_fail   = 1'b1;
								fail_code = ST_BAD_WIRE;
							end
						endcase
					end
				end else begin
					acc_n = acc_v;
					idx_n = idx_inc;
				end
			end
			PH_VARINT: begin
				if (vover) begin
					do_fail   = 1'b1;
					fail_code = ST_BAD_TAG;
				end else if (vdone) begin
					do_count   = 1'b1;
					e.has_main = 1'b1;
					acc_n      = '0;
					idx_n      = '0;
					phase_n    = PH_TAG;
				end else begin
					acc_n = acc_v;
					idx_n = idx_inc;
				end
			end
			PH_LENGTH: begin
				if (vover) begin
					do_fail   = 1'b1;
					fail_code = ST_BAD_TAG;
				end else if (vdone) begin
					acc_n = '0;
					idx_n = '0;
					if (acc_v[63:32] != '0) begin
						do_fail   = 1'b1;
						fail_code = ST_BAD_TAG;
					end else begin
						// A zero-length field is complete at its header.
						if (acc_v == '0) begin
							do_count = 1'b1;
							phase_n  = PH_TAG;
						end else begin
							rem_n   = acc_v[31:0];
							phase_n = PH_PAYLOAD;
						end
						e.has_main = 1'b1;
						e.kind     = KIND_HEADER;
					end
				end else begin
					acc_n = acc_v;
					idx_n = idx_inc;
				end
			end
			PH_PAYLOAD: begin
				rem_n = rem_dec;
				if (rem_dec == 32'd0) begin
					do_count = 1'b1;
					phase_n  = PH_TAG;
				end
				e.has_main = 1'b1;
				e.kind     = KIND_PAYLOAD;
				e.value    = 64'(s_tdata);
			end
			PH_FIXED: begin
				acc_n = acc_f;
				idx_n = idx_inc;
				if (32'(idx_inc) >= rem_q) begin
					do_count   = 1'b1;
					e.has_main = 1'b1;
					e.value    = acc_f;
					acc_n      = '0;
					idx_n      = '0;
					rem_n      = '0;
					phase_n    = PH_TAG;
				end
			end
			PH_STOP: begin
			end
			default: begin
			end
		endcase

		if (do_fail) begin
			stop_n  = fail_code;
			phase_n = PH_STOP;
			acc_n   = '0;
			idx_n   = '0;
		end

		// The counter sticks at its maximum.
		if (do_count && seen_q != '1) begin
			seen_n = seen_q + 1'b1;
		end else begin
			seen_n = seen_q;
		end

		seen_out = CW'(seen_n);
		e.count  = seen_out[15:0];

		if (s_tlast) begin
			e.has_end = 1'b1;
			if (phase_n == PH_STOP) begin
				e.status = stop_n;
			end else if (phase_n != PH_TAG || idx_n != 4'd0) begin
				e.status = ST_TRUNCATED;
			end else begin
				e.status = ST_OK;
			end
			phase_n = PH_TAG;
			acc_n   = '0;
			idx_n   = '0;
			field_n = '0;
			wire_n  = '0;
			rem_n   = '0;
			seen_n  = '0;
			stop_n  = ST_OK;
		end
	end

	assign push       = accept && (e.has_main || e.has_end);
	assign push_entry = e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			acc_q   <= '0;
			idx_q   <= '0;
			field_q <= '0;
			wire_q  <= '0;
			rem_q   <= '0;
			seen_q  <= '0;
			stop_q  <= ST_OK;
		end else if (accept) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			idx_q   <= idx_n;
			field_q <= field_n;
			wire_q  <= wire_n;
			rem_q   <= rem_n;
			seen_q  <= seen_n;
			stop_q  <= stop_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fields_q <= 16'hFFFF;
		end else if (cfg_we) begin
			max_fields_q <= cfg_wdata;
		end
	end

endmodule

/* sv/pwd_queue.sv */
`timescale 1ns / 1ps

module pwd_queue import pwd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  pwd_entry_t push_entry,
	input  logic       pop,
	output pwd_entry_t head,
	output pwd_qstat_t qstat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	pwd_entry_t      mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [LW-1:0]   level_q;
	logic            do_push, do_pop;

	assign qstat.full  = (level_q == LW'(DEPTH));
	assign qstat.empty = (level_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

/* sv/pwd_back.sv */
`timescale 1ns / 1ps

module pwd_back import pwd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  pwd_entry_t         head,
	input  pwd_qstat_t         qstat,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic [1:0]         m_tuser,
	output logic               m_tlast
);

	logic        valid_q;
	logic        half_q;
	logic [1:0]  kind_q;
	logic [30:0] fnum_q;
	logic [2:0]  wtype_q;
	logic [63:0] value_q;
	logic [2:0]  status_q;
	logic [15:0] count_q;
	logic        last_q;

	logic load;
	logic send_main;

	// half_q marks an entry whose field result is out and whose end result is still due.
	always_comb begin
		load      = !qstat.empty && (!valid_q || m_tready);
		send_main = head.has_main && !half_q;
		pop       = load && (!send_main || !head.has_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			half_q  <= send_main && head.has_end;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			count_q <= head.count;
			if (send_main) begin
				kind_q   <= head.kind;
				fnum_q   <= head.fnum;
				wtype_q  <= head.wtype;
				value_q  <= head.value;
				status_q <= ST_OK;
				last_q   <= !head.has_end;
			end else begin
				kind_q   <= KIND_END;
				fnum_q   <= '0;
				wtype_q  <= '0;
				value_q  <= '0;
				status_q <= head.status;
				last_q   <= 1'b1;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {3'b000, count_q, status_q, value_q, wtype_q, fnum_q};

endmodule
